### design/case_insensitive_substring_filter_macros.svh
// assertion macros for the substring filter rtl
`ifndef CASE_INSENSITIVE_SUBSTRING_FILTER_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// checked property, masked while reset is asserted
`define CISF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, live through reset as well
`define CISF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CISF_ASSERT(lbl, prop, msg)
`define CISF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/cisf_pkg.sv
// types, constants and helpers for the substring filter
`timescale 1ns / 1ps
`default_nettype none
package cisf_pkg;

  localparam int unsigned QUERY_LIMIT = 24;
  localparam int unsigned HIT_LIMIT   = 64;
  localparam int unsigned NAME_LIMIT  = 4096;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QLEN_W     = 5;
  localparam int unsigned NAME_IDX_W = 12;
  localparam int unsigned HIT_SLOT_W = 6;

  localparam int unsigned TOK_IDX_W  = $clog2(QUERY_LIMIT);
  localparam int unsigned TOK_CNT_W  = $clog2(QUERY_LIMIT + 1);
  localparam int unsigned NAME_CNT_W = $clog2(NAME_LIMIT);
  localparam int unsigned HIT_CNT_W  = $clog2(HIT_LIMIT + 1);

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_A    = 2'd0,
    REG_WORD_B    = 2'd1,
    REG_WORD_C    = 2'd2,
    REG_QUERY_LEN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic [NAME_IDX_W-1:0] name_index;
    logic                  matched;
    logic [HIT_SLOT_W-1:0] hit_slot;
    logic                  recorded;
    logic                  list_full;
  } out_word_t;

  typedef logic [QUERY_LIMIT-1:0][CHAR_W-1:0] tok_vec_t;

  // query loader status
  typedef struct packed {
    logic                 busy;
    logic [TOK_CNT_W-1:0] count;
  } tok_stat_t;

  // per character control broadcast to every cell
  typedef struct packed {
    logic              step;
    logic              flush;
    logic              restart;
    logic [CHAR_W-1:0] lc;
    logic              lc_space;
  } cisf_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/cisf_tokenizer.sv
// query registers and the sweep that packs them into match tokens
`timescale 1ns / 1ps
`default_nettype none
module cisf_tokenizer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [cisf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cisf_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  cfg_ready,
  output cisf_pkg::tok_vec_t                    tokens,
  output cisf_pkg::tok_stat_t                   stat
);
  import cisf_pkg::*;

  localparam logic [TOK_IDX_W-1:0] IDX_LAST = TOK_IDX_W'(QUERY_LIMIT - 1);

  logic [CFG_DATA_W-1:0] word_a_r, word_b_r, word_c_r;
  logic [QLEN_W-1:0]     qlen_r;
  tok_vec_t              tok_r;
  logic [TOK_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TOK_IDX_W-1:0]  idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  stop_r, stop_nxt;
  logic                  last_space_r, last_space_nxt;
  logic [3*CFG_DATA_W-1:0] qchars;
  logic [CHAR_W-1:0]     ch, ch_lc;
  logic [QLEN_W-1:0]     len_eff;
  logic                  take, wr_en;

  assign cfg_ready  = 1'b1;
  assign qchars     = {word_c_r, word_b_r, word_a_r};
  assign ch         = qchars[{idx_r, 3'b000} +: CHAR_W];
  assign ch_lc      = fold_case(ch);
  assign len_eff    = (qlen_r > QLEN_W'(QUERY_LIMIT)) ? QLEN_W'(QUERY_LIMIT) : qlen_r;
  assign take       = busy_r && !stop_r && (QLEN_W'(idx_r) < len_eff);
  assign tokens     = tok_r;
  assign stat.busy  = busy_r;
  assign stat.count = cnt_r;

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    busy_nxt       = busy_r;
    stop_nxt       = stop_r;
    last_space_nxt = last_space_r;
    wr_en          = 1'b0;
    if (busy_r) begin
      if (take) begin
        if (ch == NUL_CHAR) begin
          stop_nxt = 1'b1;
        end else if (!(ch_lc == SPACE_CHAR && last_space_r)) begin
          // space runs collapse into one token
          wr_en          = 1'b1;
          cnt_nxt        = cnt_r + 1'b1;
          last_space_nxt = (ch_lc == SPACE_CHAR);
        end
      end
      if (idx_r == IDX_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (cfg_valid) begin
      busy_nxt       = 1'b1;
      idx_nxt        = '0;
      cnt_nxt        = '0;
      stop_nxt       = 1'b0;
      last_space_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r     <= '0;
      word_b_r     <= '0;
      word_c_r     <= '0;
      qlen_r       <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      busy_r       <= 1'b0;
      stop_r       <= 1'b0;
      last_space_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      busy_r       <= busy_nxt;
      stop_r       <= stop_nxt;
      last_space_r <= last_space_nxt;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WORD_A:    word_a_r <= cfg_data;
          REG_WORD_B:    word_b_r <= cfg_data;
          REG_WORD_C:    word_c_r <= cfg_data;
          REG_QUERY_LEN: qlen_r   <= cfg_data[QLEN_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_r[cnt_r[TOK_IDX_W-1:0]] <= ch_lc;
    end
  end

endmodule
`default_nettype wire

### design/cisf_cell.sv
// one match cell: holds one bit of the position vector and compares against its token
`timescale 1ns / 1ps
`default_nettype none
module cisf_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cisf_pkg::cisf_ctl_t           ctl,
  input  logic [cisf_pkg::CHAR_W-1:0]   tok,
  input  logic                          en,
  input  logic                          last,
  input  logic                          prev_cur,
  output logic                          cur,
  output logic                          hit
);
  import cisf_pkg::*;

  logic bit_r, bit_nxt;
  logic nxt_val;

  // restart clears the vector before the character is handled
  assign cur = ctl.restart ? 1'b0 : bit_r;

  // advance on a token match, or stay on a space token while spaces repeat
  assign nxt_val = en && ((prev_cur && ctl.lc == tok) ||
                          (ctl.lc_space && cur && tok == SPACE_CHAR));
  assign hit     = nxt_val && last;

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.step) begin
      bit_nxt = nxt_val;
    end else if (ctl.flush) begin
      bit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule
`default_nettype wire

### design/case_insensitive_substring_filter.sv
// top level of the case-insensitive substring filter
// usage:
//   in_*  : one name character per word; a zero character ends the name,
//           restart marks the first word of a new scan
//   out_* : one word per name end with name index, match flag, hit slot,
//           recorded and list full flags
//   cfg_* : query words a, b, c and query length at indexes 0..3
// throughput: one input word per cycle, back to back, unless the loader is busy
//   or a result is stuck, set by the row of match cells that advances the vector
// a name end shows on out_valid in the cycle after it is accepted
// after every configuration write the loader sweeps the 24 query bytes
//   into tokens one byte a cycle, and in_ready stays low until the sweep is done
// reset: query cleared (empty query matches all), counters and the
//   position vector cleared, no word pending on the output
// a stalled receiver holds the result register, and in_ready stays low
//   for every input word until that result is taken
`timescale 1ns / 1ps
`default_nettype none
`include "case_insensitive_substring_filter_macros.svh"
module case_insensitive_substring_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cisf_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cisf_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cisf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cisf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cisf_pkg::*;

  // query tokens from the loader
  tok_vec_t  tokens;
  tok_stat_t tok_stat;

  // cell row wiring
  cisf_ctl_t              ctl;
  logic [QUERY_LIMIT-1:0] cur_w;
  logic [QUERY_LIMIT-1:0] hit_w;

  // scan state and result register
  logic [NAME_CNT_W-1:0] name_r, name_nxt, name_eff;
  logic [HIT_CNT_W-1:0]  hits_r, hits_nxt, hits_eff;
  logic                  found_r, found_nxt, found_eff;
  out_word_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic accept, name_end, matched, full, rec;

  cisf_tokenizer u_tokenizer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .tokens    (tokens),
    .stat      (tok_stat)
  );

  // a new word is taken unless the loader is busy or a result is stuck
  assign in_ready  = !tok_stat.busy && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign name_end  = (in_data.character == NUL_CHAR);

  assign ctl.step     = accept && !name_end;
  assign ctl.flush    = accept && name_end;
  assign ctl.restart  = accept && in_data.restart;
  assign ctl.lc       = fold_case(in_data.character);
  assign ctl.lc_space = (ctl.lc == SPACE_CHAR);

  // cell k holds bit k+1 of the position vector; bit 0 is always live
  for (genvar k = 0; k < QUERY_LIMIT; k++) begin : g_cell
    cisf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .tok      (tokens[k]),
      .en       (TOK_CNT_W'(k) < tok_stat.count),
      .last     (TOK_CNT_W'(k + 1) == tok_stat.count),
      .prev_cur ((k == 0) ? 1'b1 : cur_w[(k == 0) ? 0 : k - 1]),
      .cur      (cur_w[k]),
      .hit      (hit_w[k])
    );
  end

  // restart zeroes the counters before this word is handled
  assign name_eff  = in_data.restart ? '0 : name_r;
  assign hits_eff  = in_data.restart ? '0 : hits_r;
  assign found_eff = in_data.restart ? 1'b0 : found_r;

  // empty query matches every name
  assign matched = found_eff || (tok_stat.count == '0);
  assign full    = (hits_eff >= HIT_CNT_W'(HIT_LIMIT));
  assign rec     = matched && !full;

  always_comb begin
    name_nxt      = name_r;
    hits_nxt      = hits_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (name_end) begin
        out_nxt.name_index = NAME_IDX_W'(name_eff);
        out_nxt.matched    = matched;
        out_nxt.hit_slot   = rec ? HIT_SLOT_W'(hits_eff) : '0;
        out_nxt.recorded   = rec;
        out_nxt.list_full  = full;
        out_valid_nxt      = 1'b1;
        hits_nxt           = hits_eff + HIT_CNT_W'(rec);
        // name counter wraps after the last index
        name_nxt  = (name_eff == NAME_CNT_W'(NAME_LIMIT - 1)) ? '0 : name_eff + 1'b1;
        found_nxt = 1'b0;
      end else begin
        name_nxt  = name_eff;
        hits_nxt  = hits_eff;
        found_nxt = found_eff || (|hit_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r      <= '0;
      hits_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      name_r      <= name_nxt;
      hits_r      <= hits_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // hit count saturates at the list size
  `CISF_ASSERT(a_hits_bounded, hits_r <= HIT_CNT_W'(HIT_LIMIT), "hit count overflow")
  // a recorded hit is always a match taken while the list had room
  `CISF_ASSERT(a_rec_consistent, out_valid_r |-> (!out_r.recorded || (out_r.matched && !out_r.list_full)), "recorded without room")
  // a miss never takes a slot
  `CISF_ASSERT(a_miss_no_slot, (out_valid_r && !out_r.matched) |-> (out_r.hit_slot == '0 && !out_r.recorded), "slot on miss")
  // a name end clears the whole position vector
  `CISF_ASSERT(a_flush_clears, (accept && name_end) |=> (cur_w == '0 && !found_r), "vector not cleared")
  // packed token count never exceeds the query size
  `CISF_ASSERT(a_tok_count, tok_stat.count <= TOK_CNT_W'(QUERY_LIMIT), "token count too large")
  // reset leaves no result pending
  `CISF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "result pending after reset")

endmodule
`default_nettype wire

### tb/case_insensitive_substring_filter_test.sv
// self-checking testbench for the case-insensitive substring filter
`timescale 1ns / 1ps
module case_insensitive_substring_filter_test;
  import cisf_pkg::*;

  // hard stop, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // how long the receiver holds off once to back up the block
  localparam int HOLD_CYCLES = 400;
  // names streamed without restart to run past the hit list
  localparam int FILL_NAMES  = HIT_LIMIT + 8;

  // shadow of the query registers plus the per-name match state,
  // and the queue of verdicts still owed by the block
  class verdict_board;
    logic [CFG_DATA_W-1:0] query_word [3];
    logic [QLEN_W-1:0]     query_len;
    logic [QUERY_LIMIT:0]  live_pos;
    bit                    found;
    int unsigned           name_count;
    int unsigned           hit_total;
    out_word_t             pending_verdicts [$];
    int unsigned           mismatches;
    int unsigned           names_seen;
    int unsigned           matches_seen;
    int unsigned           full_seen;

    function new();
      foreach (query_word[i]) query_word[i] = '0;
      query_len    = '0;
      live_pos     = '0;
      found        = 0;
      name_count   = 0;
      hit_total    = 0;
      mismatches   = 0;
      names_seen   = 0;
      matches_seen = 0;
      full_seen    = 0;
    endfunction

    function void write_query_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WORD_A:    query_word[0] = value;
        REG_WORD_B:    query_word[1] = value;
        REG_WORD_C:    query_word[2] = value;
        REG_QUERY_LEN: query_len = value[QLEN_W-1:0];
        default:       ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] fold_ascii(logic [CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
      return c;
    endfunction

    // lower-cased query tokens, a space run collapsed to one token
    function int query_tokens(output logic [CHAR_W-1:0] tok [QUERY_LIMIT]);
      int used;
      int n;
      logic [CHAR_W-1:0] ch;
      used = (query_len > QUERY_LIMIT) ? QUERY_LIMIT : query_len;
      n = 0;
      for (int i = 0; i < used; i++) begin
        ch = query_word[i / 8][(i % 8) * 8 +: 8];
        if (ch == NUL_CHAR) break;
        ch = fold_ascii(ch);
        if (ch == SPACE_CHAR && n > 0 && tok[n - 1] == SPACE_CHAR) continue;
        tok[n] = ch;
        n++;
      end
      return n;
    endfunction

    function void note_character(in_word_t w);
      logic [CHAR_W-1:0] tok [QUERY_LIMIT];
      logic [CHAR_W-1:0] lc;
      logic [QUERY_LIMIT:0] cur;
      logic [QUERY_LIMIT:0] nxt;
      out_word_t v;
      int n;
      bit hit;
      bit full;
      bit rec;
      n = query_tokens(tok);
      if (w.restart) begin
        name_count = 0;
        hit_total  = 0;
        live_pos   = '0;
        found      = 0;
      end
      if (w.character == NUL_CHAR) begin
        hit  = found || n == 0;
        full = hit_total >= HIT_LIMIT;
        rec  = hit && !full;
        v.name_index = name_count[NAME_IDX_W-1:0];
        v.matched    = hit;
        v.hit_slot   = rec ? hit_total[HIT_SLOT_W-1:0] : '0;
        v.recorded   = rec;
        v.list_full  = full;
        pending_verdicts.push_back(v);
        if (rec) hit_total++;
        name_count = (name_count + 1) % NAME_LIMIT;
        live_pos   = '0;
        found      = 0;
      end else begin
        lc  = fold_ascii(w.character);
        cur = live_pos | {{QUERY_LIMIT{1'b0}}, 1'b1};
        nxt = '0;
        for (int k = 0; k < n; k++) begin
          if (cur[k] && lc == tok[k]) nxt[k + 1] = 1'b1;
        end
        if (lc == SPACE_CHAR) begin
          for (int k = 1; k <= n; k++) begin
            if (cur[k] && tok[k - 1] == SPACE_CHAR) nxt[k] = 1'b1;
          end
        end
        if (n > 0 && nxt[n]) found = 1;
        live_pos = nxt;
      end
    endfunction

    function void compare_verdict(out_word_t got);
      out_word_t exp_v;
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing expected: name_index %0d", got.name_index);
        mismatches++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      names_seen++;
      if (got.matched) matches_seen++;
      if (got.list_full) full_seen++;
      if (got.name_index !== exp_v.name_index) begin
        $error("name_index: expected %0d, actual %0d", exp_v.name_index, got.name_index);
        mismatches++;
      end
      if (got.matched !== exp_v.matched) begin
        $error("matched: expected %0d, actual %0d", exp_v.matched, got.matched);
        mismatches++;
      end
      if (got.hit_slot !== exp_v.hit_slot) begin
        $error("hit_slot: expected %0d, actual %0d", exp_v.hit_slot, got.hit_slot);
        mismatches++;
      end
      if (got.recorded !== exp_v.recorded) begin
        $error("recorded: expected %0d, actual %0d", exp_v.recorded, got.recorded);
        mismatches++;
      end
      if (got.list_full !== exp_v.list_full) begin
        $error("list_full: expected %0d, actual %0d", exp_v.list_full, got.list_full);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  verdict_board board = new();

  int  cycle_count   = 0;
  int  words_sent    = 0;
  int  cfg_writes    = 0;
  int  query_loads   = 0;
  // sender burst bookkeeping: words left in the burst
  int  burst_left    = 0;
  // one in restart_odds names starts with restart; 0 turns restarts off
  int  restart_odds  = 0;
  // raised once by the stimulus to make the receiver back off
  bit  hold_req      = 0;

  case_insensitive_substring_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // every accepted result goes straight to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.compare_verdict(out_data);
  end

  // receiver: stall patterns drawn anew each time the last one runs out,
  // plus one long hold-off on request so the block backs up
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom_range(0, 1));
        2:       out_ready = (tick % 4) != 3;
        default: out_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic in_word_t word_of(logic [CHAR_W-1:0] c, bit r);
    in_word_t w;
    w.character = c;
    w.restart   = r;
    return w;
  endfunction

  // mostly a small alphabet in both cases or a space so random names hit the query,
  // now and then any nonzero byte or a lower-case letter
  function automatic logic [CHAR_W-1:0] name_char();
    logic [CHAR_W-1:0] pool [6];
    pool = '{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43};
    case ($urandom_range(0, 9))
      6, 7:    return SPACE_CHAR;
      8:       return CHAR_W'($urandom_range(1, 255));
      9:       return CHAR_W'($urandom_range(8'h61, 8'h7a));
      default: return pool[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic bit roll_restart();
    return restart_odds != 0 && $urandom_range(1, restart_odds) == 1;
  endfunction

  // offer one word; gaps between bursts drop valid
  task automatic push_word(in_word_t w);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_character(w);
    words_sent++;
  endtask

  // sender goes quiet until every owed verdict is in, then lets the clock run on
  // so the block is idle before the next register write
  task automatic settle_outputs();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_query_reg(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // query flavors:
  //   0 short, 1 long, 2 empty, 3 length past the limit, 4 raw random,
  //   5 all ones, 6 zero inside the query, 7 all zero words
  task automatic load_query(int kind);
    logic [CHAR_W-1:0] qb [3 * 8];
    logic [CFG_DATA_W-1:0] qw [3];
    logic [QLEN_W-1:0] len;
    foreach (qb[i]) qb[i] = name_char();
    if (kind == 6) qb[$urandom_range(1, 5)] = NUL_CHAR;
    foreach (qb[i]) qw[i / 8][(i % 8) * 8 +: 8] = qb[i];
    case (kind)
      0: len = QLEN_W'($urandom_range(1, 6));
      1: len = QLEN_W'($urandom_range(22, 24));
      2: len = '0;
      3: len = QLEN_W'($urandom_range(25, 31));
      4: begin
        foreach (qw[i]) qw[i] = {$urandom(), $urandom()};
        len = QLEN_W'($urandom_range(0, 31));
      end
      5: begin
        foreach (qw[i]) qw[i] = '1;
        len = '1;
      end
      6: len = QLEN_W'($urandom_range(8, 24));
      default: begin
        foreach (qw[i]) qw[i] = '0;
        len = QLEN_W'(QUERY_LIMIT);
      end
    endcase
    write_reg(REG_WORD_A, qw[0]);
    if (kind != 0) begin
      write_reg(REG_WORD_B, qw[1]);
      write_reg(REG_WORD_C, qw[2]);
    end
    write_reg(REG_QUERY_LEN, CFG_DATA_W'(len));
    query_loads++;
  endtask

  // shaped names carry the live query with case flips and stretched
  // space runs, sometimes with one character spoiled; the rest is noise
  task automatic send_name(bit shaped, bit closed);
    logic [CHAR_W-1:0] text [$];
    logic [CHAR_W-1:0] qc [$];
    logic [CHAR_W-1:0] ch;
    in_word_t w;
    int used;
    used = (board.query_len > QUERY_LIMIT) ? QUERY_LIMIT : board.query_len;
    for (int i = 0; i < used; i++) begin
      ch = board.query_word[i / 8][(i % 8) * 8 +: 8];
      if (ch == NUL_CHAR) break;
      qc.push_back(ch);
    end
    if (shaped) begin
      repeat ($urandom_range(0, 3)) text.push_back(name_char());
      foreach (qc[i]) begin
        if (qc[i] == SPACE_CHAR) begin
          repeat ($urandom_range(1, 3)) text.push_back(SPACE_CHAR);
        end else if ((qc[i] | 8'h20) >= 8'h61 && (qc[i] | 8'h20) <= 8'h7a &&
                     $urandom_range(0, 1) == 1) begin
          text.push_back(qc[i] ^ 8'h20);
        end else begin
          text.push_back(qc[i]);
        end
      end
      if (text.size() > 0 && $urandom_range(0, 4) == 0)
        text[$urandom_range(0, text.size() - 1)] = name_char();
      repeat ($urandom_range(0, 3)) text.push_back(name_char());
    end else begin
      repeat ($urandom_range(0, 10)) text.push_back(name_char());
    end
    foreach (text[i]) begin
      // restart mostly on a name start, rarely in the middle of one
      w = word_of(text[i], (i == 0 && roll_restart()) ||
                  (restart_odds != 0 && $urandom_range(0, 199) == 0));
      push_word(w);
    end
    if (closed) push_word(word_of(NUL_CHAR, text.size() == 0 && roll_restart()));
  endtask

  initial begin
    int phase_start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WORD_A;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // query empty after reset: empty and nonempty names both match
    push_word(word_of(NUL_CHAR, 1'b1));
    push_word(word_of(8'h51, 1'b0));
    push_word(word_of(NUL_CHAR, 1'b0));
    settle_outputs();
    // query "aB  c" plus high byte 0xC8, trailing 'z' beyond the length
    write_reg(REG_WORD_A, 64'h007A_C863_2020_4261);
    write_reg(REG_QUERY_LEN, CFG_DATA_W'(6));
    // upper case and a single space still match the double space
    push_word(word_of(8'h78, 1'b0));
    push_word(word_of(8'h41, 1'b0));
    push_word(word_of(8'h42, 1'b0));
    push_word(word_of(SPACE_CHAR, 1'b0));
    push_word(word_of(8'h43, 1'b0));
    push_word(word_of(8'hC8, 1'b0));
    push_word(word_of(NUL_CHAR, 1'b0));
    // bytes above 127 are never folded, so 0xE8 misses 0xC8
    push_word(word_of(8'h41, 1'b0));
    push_word(word_of(8'h42, 1'b0));
    push_word(word_of(SPACE_CHAR, 1'b0));
    push_word(word_of(8'h43, 1'b0));
    push_word(word_of(8'hE8, 1'b0));
    push_word(word_of(NUL_CHAR, 1'b0));
    // empty name against a nonempty query
    push_word(word_of(NUL_CHAR, 1'b0));
    // query shortened in the middle of a name; position vector carries over
    push_word(word_of(8'h61, 1'b0));
    push_word(word_of(8'h62, 1'b0));
    settle_outputs();
    write_reg(REG_QUERY_LEN, CFG_DATA_W'(2));
    push_word(word_of(8'hFF, 1'b0));
    push_word(word_of(NUL_CHAR, 1'b0));

    // --- random phases, each with its own query ---
    for (int p = 0; p < 16; p++) begin
      settle_outputs();
      if (p == 10) begin
        // empty query, no restart: runs the hit list past full
        load_query(7);
        for (int j = 0; j < FILL_NAMES; j++) push_word(word_of(NUL_CHAR, 1'b0));
        settle_outputs();
      end
      load_query(p % 8);
      // keep restarts off for a while so the full list shows up on real hits
      restart_odds = (p >= 10 && p < 13) ? 0 : 30;
      if (p == 0) hold_req = 1;
      phase_start = words_sent;
      while (words_sent - phase_start < 28) begin
        send_name($urandom_range(0, 9) < 6, 1'b1);
        // one quiet spell mid-phase with everything drained
        if (p == 3 && words_sent - phase_start >= 14 && words_sent - phase_start < 24)
          settle_outputs();
      end
      // leave a name open now and then so the next query lands mid-name
      if ($urandom_range(0, 1) == 1) send_name(1'b1, 1'b0);
    end

    settle_outputs();
    repeat (8) @(posedge clk);

    $display("sent %0d words under %0d query loads (%0d register writes)",
             words_sent, query_loads, cfg_writes);
    $display("checked %0d names: %0d matched, %0d reported with the hit list full",
             board.names_seen, board.matches_seen, board.full_seen);
    if (board.pending_verdicts.size() != 0)
      $error("%0d expected results never arrived", board.pending_verdicts.size());
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
